FILE: design/pic_pkg.sv
// Shared types and constants for the point-in-convex-halfspaces block.
package pic_pkg;

  localparam int VAL_W = 24;
  localparam int ACC_W = 54;
  localparam int EPS_W = 31;
  localparam int IDX_W = 5;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W = 31;

  localparam logic [REG_IDX_W-1:0] REG_DIMS      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EPSILON   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INCLUSIVE = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_COEFF = 1'b1;

  typedef struct packed {
    logic                    func;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last_halfspace;
  } in_item_t;

  typedef struct packed {
    logic inside_this;
    logic inside_all;
    logic set_done;
  } out_item_t;

  // control carried alongside the addend into the accumulate stage
  typedef struct packed {
    logic mac;
    logic cst;
    logic last;
  } acc_ctrl_t;

endpackage

FILE: design/pic_acc.sv
// Accumulate stage: dot-product accumulator, threshold test and running AND.
module pic_acc (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  pic_pkg::acc_ctrl_t              ctrl,
  input  logic signed [pic_pkg::ACC_W-1:0] addend,
  input  logic [pic_pkg::EPS_W-1:0]       epsilon,
  input  logic                            inclusive_mode,
  output pic_pkg::out_item_t              res
);
  import pic_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] eps_ext;
  logic signed [ACC_W-1:0] thr;
  logic                    all_flag;
  logic                    pass;
  logic                    flag_and;

  always_comb begin
    sum      = acc + addend;
    eps_ext  = {{(ACC_W-EPS_W){1'b0}}, epsilon};
    thr      = inclusive_mode ? -eps_ext : eps_ext;
    pass     = sum > thr;
    flag_and = all_flag & pass;
    res.inside_this = pass;
    res.inside_all  = flag_and;
    res.set_done    = ctrl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      all_flag <= 1'b1;
    end else if (en) begin
      if (ctrl.cst) begin
        // finish the halfspace: clear the sum, restart the AND after the set
        acc      <= '0;
        all_flag <= ctrl.last ? 1'b1 : flag_and;
      end else if (ctrl.mac) begin
        acc <= sum;
      end
    end
  end

endmodule

FILE: design/point_in_convex_halfspaces.sv
// A constant term passes through stage 1, stage 2 and the output register before its result shows on out_valid.
// Throughput: one item per cycle while in_ready is high; coordinate store reads in the same cycle as acceptance.
// in_ready drops only while a result waits and the next result is ready at the tail.
// Synchronous active-high reset clears the accumulator, sets the running AND and
// empties the pipe; the coordinate store is not cleared.
module point_in_convex_halfspaces #(
  parameter int MAX_DIM = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pic_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pic_pkg::out_item_t             out_data,
  input  logic                           wr_en,
  input  logic [pic_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [pic_pkg::CFG_W-1:0]      wr_data
);
  import pic_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [7:0] MAX_DIM_W = 8'(MAX_DIM);

  logic [IDX_W-1:0] dims_in_use;
  logic [EPS_W-1:0] epsilon;
  logic             inclusive_mode;

  logic signed [VAL_W-1:0] point_store [MAX_DIM];
  logic signed [VAL_W-1:0] rd_data;

  logic       en;
  logic       acc_in;
  logic [7:0] dim8;
  logic [7:0] pos8;
  logic       is_mac;
  logic       is_cst;
  logic       do_load;

  logic                    s1_mac;
  logic                    s1_cst;
  logic                    s1_last;
  logic signed [VAL_W-1:0] s1_val;
  logic signed [2*VAL_W-1:0] prod;
  logic signed [ACC_W-1:0] s1_add;

  acc_ctrl_t               s2_ctrl;
  logic signed [ACC_W-1:0] s2_add;
  out_item_t               res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use    <= 5'd3;
      epsilon        <= 31'd4295;
      inclusive_mode <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIMS:      dims_in_use    <= wr_data[IDX_W-1:0];
        REG_EPSILON:   epsilon        <= wr_data[EPS_W-1:0];
        REG_INCLUSIVE: inclusive_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // hold the whole pipe only when a result would land on a stalled output
  assign en       = !(out_valid && !out_ready && s2_ctrl.cst);
  assign in_ready = en;
  assign acc_in   = in_valid && in_ready;

  always_comb begin
    pos8    = {3'b0, in_data.index};
    dim8    = ({3'b0, dims_in_use} > MAX_DIM_W) ? MAX_DIM_W : {3'b0, dims_in_use};
    is_mac  = acc_in && (in_data.func == FUNC_COEFF) && (pos8 < dim8);
    is_cst  = acc_in && (in_data.func == FUNC_COEFF) && (pos8 == dim8);
    do_load = acc_in && (in_data.func == FUNC_LOAD) && (pos8 < MAX_DIM_W);
  end

  // coordinate store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_load) begin
      point_store[pos8[AW-1:0]] <= in_data.value;
    end
    if (en && is_mac) begin
      rd_data <= point_store[pos8[AW-1:0]];
    end
  end

  // stage 1: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mac <= 1'b0;
      s1_cst <= 1'b0;
    end else if (en) begin
      s1_mac <= is_mac;
      s1_cst <= is_cst;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_val  <= in_data.value;
      s1_last <= in_data.last_halfspace;
    end
  end

  always_comb begin
    prod = s1_val * rd_data;
    if (s1_cst) begin
      s1_add = {{(ACC_W-VAL_W-16){s1_val[VAL_W-1]}}, s1_val, 16'b0};
    end else begin
      s1_add = {{(ACC_W-2*VAL_W){prod[2*VAL_W-1]}}, prod};
    end
  end

  // stage 2: accumulate and test
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (en) begin
      s2_ctrl.mac  <= s1_mac;
      s2_ctrl.cst  <= s1_cst;
      s2_ctrl.last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_add <= s1_add;
    end
  end

  pic_acc u_acc (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .ctrl           (s2_ctrl),
    .addend         (s2_add),
    .epsilon        (epsilon),
    .inclusive_mode (inclusive_mode),
    .res            (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && s2_ctrl.cst) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_ctrl.cst) begin
      out_data <= res;
    end
  end

endmodule

FILE: design/pic_checker.sv
// Port-level checks for the point-in-convex-halfspaces block.
module pic_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pic_pkg::out_item_t out_data
);
  import pic_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the pipe empties on reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // the running AND never passes where this halfspace fails
  a_all_implies_this: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.inside_all |-> out_data.inside_this)
    else $error("inside_all set with inside_this clear");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

bind point_in_convex_halfspaces pic_checker u_pic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
